>>> rtl/dpbp_pkg.sv
// Shared types and constants for the depth pixel back-projection pipeline.
// Used by dpbp_lateral and depth_pixel_back_project; depends on nothing.
`default_nettype none
package dpbp_pkg;

  // Largest image dimension; pixel indices at or above it are clamped.
  localparam int MAX_IMAGE_DIM = 2048;

  // Field widths
  localparam int PIX_W    = 11;
  localparam int CENTER_W = 12;
  localparam int DEPTH_W  = 16;
  localparam int INVF_W   = 24;
  localparam int SCALE_W  = 20;
  localparam int XY_W     = 24;
  localparam int Z_W      = 23;
  localparam int COLOR_W  = 8;
  localparam int CFG_W    = 24;
  localparam int CFG_IDX_W = 3;

  // Pipeline depth from accept to result strobe
  localparam int LATENCY = 6;

  // Configuration register indices
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X_HALF = 3'd0,
    REG_CENTER_Y_HALF = 3'd1,
    REG_INV_FOCAL_X   = 3'd2,
    REG_INV_FOCAL_Y   = 3'd3,
    REG_OUTPUT_SCALE  = 3'd4
  } dpbp_reg_e;

  typedef struct packed {
    logic [PIX_W-1:0]   column;
    logic [PIX_W-1:0]   row;
    logic [DEPTH_W-1:0] depth;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } dpbp_in_t;

  typedef struct packed {
    logic signed [XY_W-1:0] point_x;
    logic signed [XY_W-1:0] point_y;
    logic [Z_W-1:0]         point_z;
    logic [COLOR_W-1:0]     out_red;
    logic [COLOR_W-1:0]     out_green;
    logic [COLOR_W-1:0]     out_blue;
  } dpbp_out_t;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } dpbp_rgb_t;

endpackage
`default_nettype wire

>>> rtl/dpbp_lateral.sv
// One lateral coordinate lane (x or y) of the back-projection pipeline.
// Six register stages, no stall; depends on dpbp_pkg.
`default_nettype none
module dpbp_lateral (
  input  wire logic                          clk_i,
  input  wire logic [dpbp_pkg::PIX_W-1:0]    pix_i,
  input  wire logic [dpbp_pkg::CENTER_W-1:0] center_half_i,
  input  wire logic [dpbp_pkg::INVF_W-1:0]   inv_focal_i,
  input  wire logic [dpbp_pkg::SCALE_W-1:0]  scale_i,
  input  wire logic [dpbp_pkg::DEPTH_W-1:0]  depth_i,
  output logic signed [dpbp_pkg::XY_W-1:0]   coord_o
);
  import dpbp_pkg::*;

  localparam int P1_W  = CENTER_W + DEPTH_W;
  localparam int P2_W  = P1_W + INVF_W;
  localparam int T_W   = P2_W + 1 - 25;
  localparam int Q_W   = T_W + SCALE_W;
  localparam int M_W   = Q_W + 1 - 16;
  localparam logic [M_W-1:0] POS_MAX = M_W'((1 << (XY_W - 1)) - 1);
  localparam logic [M_W-1:0] NEG_MAG = M_W'(1 << (XY_W - 1));

  logic [PIX_W-1:0]    pix_c;
  logic [CENTER_W-1:0] twice;
  logic                neg_c;

  logic [CENTER_W-1:0] dh_q;
  logic [DEPTH_W-1:0]  depth_q;
  logic [P1_W-1:0]     p1_q;
  logic [P2_W-1:0]     p2_q;
  logic [T_W-1:0]      t_q;
  logic [Q_W-1:0]      q_q;
  logic [LATENCY-2:0]  neg_q;

  logic [P2_W:0]       rnd1;
  logic [Q_W:0]        rnd2;
  logic [M_W-1:0]      m;
  logic [XY_W-1:0]     coord_d;

  // Clamp index and form the half-pixel offset magnitude and sign
  always_comb begin
    pix_c = (32'(pix_i) >= MAX_IMAGE_DIM) ? PIX_W'(MAX_IMAGE_DIM - 1) : pix_i;
    twice = {pix_c, 1'b0};
    neg_c = twice < center_half_i;
  end

  // Round after the inverse-focal and scale multiplies, half away from zero on the magnitude
  always_comb begin
    rnd1 = {1'b0, p2_q} + ((P2_W + 1)'(1) << 24);
    rnd2 = {1'b0, q_q} + ((Q_W + 1)'(1) << 15);
    m    = rnd2[Q_W:16];
    if (neg_q[LATENCY-2]) begin
      coord_d = (m > NEG_MAG) ? (XY_W'(0) - NEG_MAG[XY_W-1:0])
                              : (XY_W'(0) - m[XY_W-1:0]);
    end else begin
      coord_d = (m > POS_MAX) ? POS_MAX[XY_W-1:0] : m[XY_W-1:0];
    end
  end

  // Advance the data pipeline every cycle
  always_ff @(posedge clk_i) begin
    dh_q    <= neg_c ? (center_half_i - twice) : (twice - center_half_i);
    depth_q <= depth_i;
    neg_q   <= {neg_q[LATENCY-3:0], neg_c};
    p1_q    <= P1_W'(dh_q) * P1_W'(depth_q);
    p2_q    <= P2_W'(p1_q) * P2_W'(inv_focal_i);
    t_q     <= rnd1[P2_W:25];
    q_q     <= Q_W'(t_q) * Q_W'(scale_i);
    coord_o <= coord_d;
  end

endmodule
`default_nettype wire

>>> rtl/depth_pixel_back_project.sv
// Top level of the pinhole depth back-projection pipeline.
// Depends on dpbp_pkg and dpbp_lateral.
// Throughput: one pixel word per cycle; busy stays low, the pipeline never stalls.
// The latency is set by the six-stage multiply chain of the x and y lanes.
// Reset clears the valid bits and loads the default configuration registers.
`default_nettype none
module depth_pixel_back_project (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start,
  output logic                                busy,
  input  wire dpbp_pkg::dpbp_in_t             in_word_i,
  output logic                                done_o,
  output dpbp_pkg::dpbp_out_t                 out_word_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [dpbp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [dpbp_pkg::CFG_W-1:0]     cfg_data_i
);
  import dpbp_pkg::*;

  localparam int ZP_W = DEPTH_W + SCALE_W;

  logic [CENTER_W-1:0] center_x_q, center_y_q;
  logic [INVF_W-1:0]   inv_fx_q, inv_fy_q;
  logic [SCALE_W-1:0]  scale_q;

  logic [LATENCY-1:0]  vld_q;
  dpbp_rgb_t           rgb_q [LATENCY];
  logic [DEPTH_W-1:0]  depth_q;
  logic [ZP_W-1:0]     zp_q;
  logic [ZP_W:0]       z_rnd;
  logic [ZP_W-16:0]    z_q [LATENCY-2];

  logic signed [XY_W-1:0] x_s, y_s;
  logic                accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= CENTER_W'(800);
      center_y_q <= CENTER_W'(800);
      inv_fx_q   <= INVF_W'(17373);
      inv_fy_q   <= INVF_W'(17373);
      scale_q    <= SCALE_W'(176206);
    end else if (cfg_we_i) begin
      case (dpbp_reg_e'(cfg_idx_i))
        REG_CENTER_X_HALF: center_x_q <= cfg_data_i[CENTER_W-1:0];
        REG_CENTER_Y_HALF: center_y_q <= cfg_data_i[CENTER_W-1:0];
        REG_INV_FOCAL_X:   inv_fx_q   <= cfg_data_i[INVF_W-1:0];
        REG_INV_FOCAL_Y:   inv_fy_q   <= cfg_data_i[INVF_W-1:0];
        REG_OUTPUT_SCALE:  scale_q    <= cfg_data_i[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // Carry valid bits alongside the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LATENCY-2:0], accept};
    end
  end

  // Round the scaled depth; it always fits the output range
  assign z_rnd = {1'b0, zp_q} + ((ZP_W + 1)'(1) << 15);

  // Advance color and depth words
  always_ff @(posedge clk_i) begin
    rgb_q[0] <= '{red: in_word_i.red, green: in_word_i.green, blue: in_word_i.blue};
    for (int i = 1; i < LATENCY; i++) begin
      rgb_q[i] <= rgb_q[i-1];
    end
    depth_q <= in_word_i.depth;
    zp_q    <= ZP_W'(depth_q) * ZP_W'(scale_q);
    z_q[0]  <= z_rnd[ZP_W:16];
    for (int i = 1; i < LATENCY - 2; i++) begin
      z_q[i] <= z_q[i-1];
    end
  end

  dpbp_lateral u_lat_x (
    .clk_i         (clk_i),
    .pix_i         (in_word_i.column),
    .center_half_i (center_x_q),
    .inv_focal_i   (inv_fx_q),
    .scale_i       (scale_q),
    .depth_i       (in_word_i.depth),
    .coord_o       (x_s)
  );

  dpbp_lateral u_lat_y (
    .clk_i         (clk_i),
    .pix_i         (in_word_i.row),
    .center_half_i (center_y_q),
    .inv_focal_i   (inv_fy_q),
    .scale_i       (scale_q),
    .depth_i       (in_word_i.depth),
    .coord_o       (y_s)
  );

  // Assemble the result word from the last stage
  assign done_o               = vld_q[LATENCY-1];
  assign out_word_o.point_x   = x_s;
  assign out_word_o.point_y   = y_s;
  assign out_word_o.point_z   = Z_W'(z_q[LATENCY-3]);
  assign out_word_o.out_red   = rgb_q[LATENCY-1].red;
  assign out_word_o.out_green = rgb_q[LATENCY-1].green;
  assign out_word_o.out_blue  = rgb_q[LATENCY-1].blue;

endmodule
`default_nettype wire
